/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, masked while reset is asserted.
`define ISG_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the standard clock and reset names.
`define ISG_ASSERT(lbl, prop, msg) \
  `ISG_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/isg_pkg.sv */
// Shared types, constants and microcode word layout of the point generator.
package isg_pkg;

  localparam int ROW_W   = 7;
  localparam int COL_W   = 7;
  localparam int PHASE_W = 16;
  localparam int POINT_W = 14;
  localparam int LEVEL_W = 8;
  localparam int CTR_W   = 12;
  localparam int SCALE_W = 10;
  localparam int RUN_W   = 16;
  localparam int SIN_W   = 15;
  localparam int PROD_W  = 45;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int COL_COUNT                = 128;
  localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;

  localparam logic [CTR_W-1:0]   CENTER_X_RESET = 12'd320;
  localparam logic [CTR_W-1:0]   CENTER_Y_RESET = 12'd240;
  localparam logic [SCALE_W-1:0] SCALE_RESET    = 10'd115;

  localparam logic [29:0]          TURN_PER_RAD = 30'd683565276;
  localparam logic [63:0]          HALF_PI_Q30  = 64'd1686629713;
  localparam logic [PHASE_W-1:0]   QUARTER_TURN = 16'h4000;

  localparam int unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_SCALE    = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_CAP_PB,
    ST_SIN_A,
    ST_COS_B,
    ST_SIN_B,
    ST_ADD_X,
    ST_ADD_Y,
    ST_SCALE_Y,
    ST_EMIT
  } step_e;

  typedef enum logic [1:0] {MUL_A, MUL_B, MUL_SX, MUL_SY} mul_sel_e;
  typedef enum logic [1:0] {LK_COS_A, LK_SIN_A, LK_COS_B, LK_SIN_B} lk_sel_e;
  typedef enum logic [2:0] {ACC_NONE, ACC_LOAD_X, ACC_LOAD_Y, ACC_ADD_X, ACC_ADD_Y} acc_op_e;
  typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT} jmp_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    lk_sel_e  lk_sel;
    acc_op_e  acc_op;
    logic     load_item;
    logic     cap_pa;
    logic     cap_pb;
    logic     cap_px;
    logic     emit;
    jmp_e     jmp;
  } ucode_t;

  typedef struct packed {
    ucode_t word;
    logic   adv;
  } ctl_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  localparam ucode_t UCODE_NOP = '{
    mul_sel:   MUL_A,
    lk_sel:    LK_COS_A,
    acc_op:    ACC_NONE,
    load_item: 1'b0,
    cap_pa:    1'b0,
    cap_pb:    1'b0,
    cap_px:    1'b0,
    emit:      1'b0,
    jmp:       JMP_NEXT
  };

endpackage

/* rtl/isg_if.sv */
// Valid/ready channel interfaces for input items and result points.
interface isg_in_if;
  logic                         valid;
  logic                         ready;
  logic [isg_pkg::ROW_W-1:0]    row;
  logic [isg_pkg::COL_W-1:0]    col;
  logic [isg_pkg::PHASE_W-1:0]  time_phase;

  modport source (output valid, output row, output col, output time_phase, input ready);
  modport sink   (input valid, input row, input col, input time_phase, output ready);
endinterface

interface isg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [isg_pkg::POINT_W-1:0]  point_x;
  logic signed [isg_pkg::POINT_W-1:0]  point_y;
  logic [isg_pkg::LEVEL_W-1:0]         red_level;
  logic [isg_pkg::LEVEL_W-1:0]         green_level;
  logic                                last_in_row;

  modport source (output valid, output point_x, output point_y, output red_level,
                  output green_level, output last_in_row, input ready);
  modport sink   (input valid, input point_x, input point_y, input red_level,
                  input green_level, input last_in_row, output ready);
endinterface

/* rtl/isg_sine.sv */
// Two-stage quarter-wave sine lookup: phase in turns to signed Q13 sine.
module isg_sine #(
  parameter int SINE_TABLE_DEPTH = isg_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic [isg_pkg::PHASE_W-1:0]      phase_i,
  output logic signed [isg_pkg::SIN_W-1:0] value_o
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

  typedef logic [13:0] rom_t [0:SINE_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    int          k;
    int          n;
    for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      theta = (64'(k) * isg_pkg::HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
      t2    = (theta * theta + (64'd1 << 29)) >> 30;
      term  = theta;
      sum   = theta;
      for (n = 1; n <= 7; n++) begin
        term = ((term * t2) >> 30) / isg_pkg::TAYLOR_DIV[n-1];
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      r[k] = 14'((sum + (64'd1 << 16)) >> 17);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [28:0]            scaled;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          addr_d;
  logic [AW-1:0]          addr_q;
  logic                   neg_q;
  logic                   neg2_q;
  logic [13:0]            rom_q;
  logic signed [isg_pkg::SIN_W-1:0] mag;

  always_comb begin
    scaled = 29'(phase_i[13:0]) * 29'(SINE_TABLE_DEPTH) + 29'(1 << 13);
    idx    = AW'(scaled >> 14);
    addr_d = phase_i[14] ? (AW'(SINE_TABLE_DEPTH) - idx) : idx;
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    neg_q  <= phase_i[15];
    rom_q  <= SINE_ROM[addr_q];
    neg2_q <= neg_q;
  end

  assign mag     = {1'b0, rom_q};
  assign value_o = neg2_q ? -mag : mag;

endmodule

/* rtl/isg_seq.sv */
// Microcode sequencer: step counter, program table and jump control.
module isg_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  isg_pkg::sts_t   sts_i,
  output isg_pkg::ctl_t   ctl_o
);

  function automatic isg_pkg::ucode_t ucode_of(isg_pkg::step_e s);
    isg_pkg::ucode_t w;
    w = isg_pkg::UCODE_NOP;
    unique case (s)
      isg_pkg::ST_IDLE: begin
        w.load_item = 1'b1;
        w.jmp       = isg_pkg::JMP_WAIT_IN;
      end
      isg_pkg::ST_MUL_A: begin
        w.mul_sel = isg_pkg::MUL_A;
      end
      isg_pkg::ST_MUL_B: begin
        w.mul_sel = isg_pkg::MUL_B;
        w.cap_pa  = 1'b1;
      end
      isg_pkg::ST_CAP_PB: begin
        w.cap_pb = 1'b1;
        w.lk_sel = isg_pkg::LK_COS_A;
      end
      isg_pkg::ST_SIN_A: begin
        w.lk_sel = isg_pkg::LK_SIN_A;
      end
      isg_pkg::ST_COS_B: begin
        w.lk_sel = isg_pkg::LK_COS_B;
        w.acc_op = isg_pkg::ACC_LOAD_X;
      end
      isg_pkg::ST_SIN_B: begin
        w.lk_sel = isg_pkg::LK_SIN_B;
        w.acc_op = isg_pkg::ACC_LOAD_Y;
      end
      isg_pkg::ST_ADD_X: begin
        w.acc_op = isg_pkg::ACC_ADD_X;
      end
      isg_pkg::ST_ADD_Y: begin
        w.acc_op  = isg_pkg::ACC_ADD_Y;
        w.mul_sel = isg_pkg::MUL_SX;
      end
      isg_pkg::ST_SCALE_Y: begin
        w.mul_sel = isg_pkg::MUL_SY;
        w.cap_px  = 1'b1;
      end
      isg_pkg::ST_EMIT: begin
        w.emit = 1'b1;
        w.jmp  = isg_pkg::JMP_WAIT_OUT;
      end
      default: begin
        w.jmp = isg_pkg::JMP_WAIT_OUT;
      end
    endcase
    return w;
  endfunction

  isg_pkg::step_e   step_d;
  isg_pkg::step_e   step_q;
  isg_pkg::ucode_t  word;
  logic             adv;

  always_comb begin
    word = ucode_of(step_q);
    unique case (word.jmp)
      isg_pkg::JMP_WAIT_IN:  adv = in_valid_i;
      isg_pkg::JMP_WAIT_OUT: adv = sts_i.out_free;
      default:               adv = 1'b1;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (adv) begin
      if (word.jmp == isg_pkg::JMP_WAIT_OUT) begin
        step_d = isg_pkg::ST_IDLE;
      end else begin
        step_d = isg_pkg::step_e'(4'(step_q) + 4'd1);
      end
    end
  end

  always_comb begin
    ctl_o.word = word;
    ctl_o.adv  = adv;
    in_ready_o = rst_ni && (word.jmp == isg_pkg::JMP_WAIT_IN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= isg_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

/* rtl/isg_dp.sv */
// Datapath: config registers, running pair, shared multiplier, sine unit, output beat.
module isg_dp #(
  parameter int SINE_TABLE_DEPTH = isg_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  isg_pkg::ctl_t                       ctl_i,
  output isg_pkg::sts_t                       sts_o,
  input  logic                                cfg_we_i,
  input  logic [isg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [isg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [isg_pkg::ROW_W-1:0]           row_i,
  input  logic [isg_pkg::COL_W-1:0]           col_i,
  input  logic [isg_pkg::PHASE_W-1:0]         time_phase_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [isg_pkg::POINT_W-1:0]  point_x_o,
  output logic signed [isg_pkg::POINT_W-1:0]  point_y_o,
  output logic [isg_pkg::LEVEL_W-1:0]         red_level_o,
  output logic [isg_pkg::LEVEL_W-1:0]         green_level_o,
  output logic                                last_in_row_o
);

  localparam int ROWS = 2 ** isg_pkg::ROW_W;

  typedef logic [15:0] row_ofs_t [ROWS];

  function automatic row_ofs_t build_row_ofs();
    row_ofs_t t;
    int       r;
    for (r = 0; r < ROWS; r++) begin
      t[r] = 16'((r * 62 * 8192 + 500) / 1000);
    end
    return t;
  endfunction

  localparam row_ofs_t ROW_OFS = build_row_ofs();

  logic [isg_pkg::CTR_W-1:0]    center_x_q;
  logic [isg_pkg::CTR_W-1:0]    center_y_q;
  logic [isg_pkg::SCALE_W-1:0]  scale_q;
  logic [isg_pkg::RUN_W-1:0]    run_x_d;
  logic [isg_pkg::RUN_W-1:0]    run_x_q;
  logic [isg_pkg::RUN_W-1:0]    run_y_d;
  logic [isg_pkg::RUN_W-1:0]    run_y_q;
  logic                         out_valid_q;

  logic [isg_pkg::ROW_W-1:0]    row_q;
  logic [isg_pkg::COL_W-1:0]    col_q;
  logic [isg_pkg::PHASE_W-1:0]  tph_q;
  logic [isg_pkg::PROD_W-1:0]   prod_q;
  logic [isg_pkg::PHASE_W-1:0]  pa_q;
  logic [isg_pkg::PHASE_W-1:0]  pb_q;
  logic [12:0]                  px_q;

  logic signed [22:0]           ang_a;
  logic signed [22:0]           ang_b;
  logic signed [22:0]           mul_a;
  logic signed [30:0]           mul_b;
  logic signed [53:0]           mul_p;
  logic [isg_pkg::PROD_W-1:0]   turn_sum;
  logic [isg_pkg::PHASE_W-1:0]  turn_ph;
  logic [26:0]                  rnd_sum;
  logic [12:0]                  rnd;
  logic [isg_pkg::PHASE_W-1:0]  lk_phase;
  logic signed [isg_pkg::SIN_W-1:0] sin_val;
  logic [isg_pkg::RUN_W-1:0]    sin_ext;
  logic                         go;

  assign go = ctl_i.adv;

  always_comb begin
    ang_a = signed'({{7{run_x_q[15]}}, run_x_q}) + signed'({2'b00, row_q, 14'b0});
    ang_b = signed'({{7{run_y_q[15]}}, run_y_q}) + signed'({7'b0, ROW_OFS[row_q]});
    unique case (ctl_i.word.mul_sel)
      isg_pkg::MUL_A: begin
        mul_a = ang_a;
        mul_b = signed'({1'b0, isg_pkg::TURN_PER_RAD});
      end
      isg_pkg::MUL_B: begin
        mul_a = ang_b;
        mul_b = signed'({1'b0, isg_pkg::TURN_PER_RAD});
      end
      isg_pkg::MUL_SX: begin
        mul_a = signed'({{7{run_x_q[15]}}, run_x_q});
        mul_b = signed'({21'b0, scale_q});
      end
      default: begin
        mul_a = signed'({{7{run_y_q[15]}}, run_y_q});
        mul_b = signed'({21'b0, scale_q});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    turn_sum = prod_q + isg_pkg::PROD_W'(1 << 28);
    turn_ph  = turn_sum[44:29];
    rnd_sum  = prod_q[26:0] + 27'd4096;
    rnd      = rnd_sum[25:13];
  end

  always_comb begin
    unique case (ctl_i.word.lk_sel)
      isg_pkg::LK_COS_A: lk_phase = pa_q + isg_pkg::QUARTER_TURN;
      isg_pkg::LK_SIN_A: lk_phase = pa_q;
      isg_pkg::LK_COS_B: lk_phase = pb_q + isg_pkg::QUARTER_TURN;
      default:           lk_phase = pb_q;
    endcase
  end

  isg_sine #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine (
    .clk_i   (clk_i),
    .phase_i (lk_phase),
    .value_o (sin_val)
  );

  assign sin_ext = {sin_val[isg_pkg::SIN_W-1], sin_val};

  always_comb begin
    run_x_d = run_x_q;
    run_y_d = run_y_q;
    if (go) begin
      if (ctl_i.word.load_item && (col_i == '0)) begin
        run_x_d = '0;
        run_y_d = '0;
      end
      unique case (ctl_i.word.acc_op)
        isg_pkg::ACC_LOAD_X: run_x_d = sin_ext;
        isg_pkg::ACC_LOAD_Y: run_y_d = sin_ext;
        isg_pkg::ACC_ADD_X:  run_x_d = run_x_q + sin_ext;
        isg_pkg::ACC_ADD_Y:  run_y_d = run_y_q + sin_ext;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= isg_pkg::CENTER_X_RESET;
      center_y_q  <= isg_pkg::CENTER_Y_RESET;
      scale_q     <= isg_pkg::SCALE_RESET;
      run_x_q     <= '0;
      run_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (isg_pkg::cfg_reg_e'(cfg_idx_i))
          isg_pkg::REG_CENTER_X: center_x_q <= cfg_data_i;
          isg_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i;
          isg_pkg::REG_SCALE:    scale_q    <= cfg_data_i[isg_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      run_x_q <= run_x_d;
      run_y_q <= run_y_d;
      if (go && ctl_i.word.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && ctl_i.word.load_item) begin
      row_q <= row_i;
      col_q <= col_i;
      tph_q <= time_phase_i;
    end
    if (go) begin
      prod_q <= mul_p[isg_pkg::PROD_W-1:0];
    end
    if (go && ctl_i.word.cap_pa) begin
      pa_q <= turn_ph;
    end
    if (go && ctl_i.word.cap_pb) begin
      pb_q <= turn_ph - tph_q;
    end
    if (go && ctl_i.word.cap_px) begin
      px_q <= rnd;
    end
    if (go && ctl_i.word.emit) begin
      point_x_o     <= signed'(14'({2'b00, center_x_q}) - {px_q[12], px_q});
      point_y_o     <= signed'(14'({2'b00, center_y_q}) - {rnd[12], rnd});
      red_level_o   <= {row_q, 1'b0};
      green_level_o <= {col_q, 1'b0};
      last_in_row_o <= ({4'b0, col_q} == 11'(isg_pkg::COL_COUNT - 1));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

/* rtl/iterated_sincos_point_generator.sv */
// Top level of the iterated sine/cosine point generator.
// Takes one item (row, column, frame phase) at a time and returns one screen point
// per item; column 0 restarts the running pair. The result beat of an item is loaded
// in the last step of the microcode program, and the next item is taken only after
// that step, so the peak item rate is set by the length of the 11-step microcode
// program, which routes both angle-to-turn products and both scale products
// through one shared multiplier and four lookups through one two-stage sine ROM.
// A finished result waits in the output register; the block then takes the next
// item and stalls only on its final step if that result has still not been taken.
module iterated_sincos_point_generator #(
  parameter int SINE_TABLE_DEPTH = isg_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  isg_in_if.sink                          in_i,
  isg_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [isg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [isg_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  isg_pkg::ctl_t ctl;
  isg_pkg::sts_t sts;

  isg_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  isg_dp #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .row_i         (in_i.row),
    .col_i         (in_i.col),
    .time_phase_i  (in_i.time_phase),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .point_x_o     (out_o.point_x),
    .point_y_o     (out_o.point_y),
    .red_level_o   (out_o.red_level),
    .green_level_o (out_o.green_level),
    .last_in_row_o (out_o.last_in_row)
  );

endmodule

/* rtl/isg_checker.sv */
// Port-level assertions for the point generator and their bind.
`include "assert_macros.svh"

module isg_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [isg_pkg::POINT_W-1:0]  point_x_i,
  input logic signed [isg_pkg::POINT_W-1:0]  point_y_i
);

  logic                             out_stall;
  logic [2*isg_pkg::POINT_W-1:0]    point_xy;

  assign out_stall = out_valid_i && !out_ready_i;
  assign point_xy  = {point_x_i, point_y_i};

  `ISG_ASSERT(a_out_hold, out_stall |=> out_valid_i, "result beat dropped while stalled")
  `ISG_ASSERT(a_out_stable, out_stall |=> $stable(point_xy), "stalled result changed")
  `ISG_ASSERT(a_one_at_a_time, in_valid_i && in_ready_i |=> !in_ready_i, "item taken while busy")
  `ISG_ASSERT(a_emit_while_busy, $rose(out_valid_i) |-> $past(!in_ready_i), "beat while idle")

endmodule

bind iterated_sincos_point_generator isg_checker u_isg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .point_x_i   (out_o.point_x),
  .point_y_i   (out_o.point_y)
);

/* tb/sv/isg_point_checker.sv */
// Checker for the point generator: predicts each point from accepted items and compares.
module isg_point_checker #(
  parameter int SINE_TABLE_DEPTH = isg_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  isg_in_if                               in_mon,
  isg_out_if                              out_mon,
  input  logic                            cfg_we_i,
  input  logic [isg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [isg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     items_o,
  output int unsigned                     points_o,
  output int unsigned                     pending_o
);

  localparam int D = SINE_TABLE_DEPTH;

  typedef struct {
    logic signed [isg_pkg::POINT_W-1:0] px;
    logic signed [isg_pkg::POINT_W-1:0] py;
    logic [isg_pkg::LEVEL_W-1:0]        red;
    logic [isg_pkg::LEVEL_W-1:0]        green;
    logic                               last;
  } point_t;

  int                               quarter_wave [0:D];
  logic [isg_pkg::CTR_W-1:0]        ctr_x;
  logic [isg_pkg::CTR_W-1:0]        ctr_y;
  logic [isg_pkg::SCALE_W-1:0]      px_scale;
  logic signed [isg_pkg::RUN_W-1:0] pair_x;
  logic signed [isg_pkg::RUN_W-1:0] pair_y;
  point_t                           due_points [$];
  point_t                           want;

  function automatic int taylor_quarter(int unsigned k);
    longint unsigned theta, t2, term, acc;
    int n;
    theta = (64'(k) * isg_pkg::HALF_PI_Q30 + 64'(D / 2)) / 64'(D);
    t2    = (theta * theta + (64'd1 << 29)) >> 30;
    term  = theta;
    acc   = theta;
    for (n = 1; n <= 7; n++) begin
      term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc -= term;
      end else begin
        acc += term;
      end
    end
    return int'((acc + 64'd65536) >> 17);
  endfunction

  function automatic int wave(logic [isg_pkg::PHASE_W-1:0] ph);
    int idx;
    int v;
    idx = (int'(ph[13:0]) * D + 8192) >> 14;
    if (idx > D) idx = D;
    if (ph[14]) idx = D - idx;
    v = quarter_wave[idx];
    return ph[15] ? -v : v;
  endfunction

  function automatic logic [isg_pkg::PHASE_W-1:0] to_turns(int r);
    logic [63:0] p;
    p = 64'(longint'(r) * longint'(isg_pkg::TURN_PER_RAD)) + 64'd268435456;
    return p[44:29];
  endfunction

  function automatic logic [isg_pkg::POINT_W-1:0] place(logic [isg_pkg::CTR_W-1:0] ctr, int v);
    int p;
    int rounded;
    p = int'(px_scale) * v;
    rounded = ((p + 4096 + 33554432) >>> 13) - 4096;
    return isg_pkg::POINT_W'(int'(ctr) - rounded);
  endfunction

  function automatic point_t trace_point(logic [isg_pkg::ROW_W-1:0] row,
                                         logic [isg_pkg::COL_W-1:0] col,
                                         logic [isg_pkg::PHASE_W-1:0] tph);
    int a, b, nx, ny;
    logic [isg_pkg::PHASE_W-1:0] pa, pb;
    point_t pt;
    if (col == '0) begin
      pair_x = '0;
      pair_y = '0;
    end
    a  = int'(pair_x) + int'(row) * 2 * 8192;
    b  = int'(pair_y) + (int'(row) * 62 * 8192 + 500) / 1000;
    pa = to_turns(a);
    pb = isg_pkg::PHASE_W'(to_turns(b) - tph);
    nx = wave(isg_pkg::PHASE_W'(pa + isg_pkg::QUARTER_TURN))
       + wave(isg_pkg::PHASE_W'(pb + isg_pkg::QUARTER_TURN));
    ny = wave(pa) + wave(pb);
    pair_x = isg_pkg::RUN_W'(nx);
    pair_y = isg_pkg::RUN_W'(ny);
    pt.px    = place(ctr_x, nx);
    pt.py    = place(ctr_y, ny);
    pt.red   = {row, 1'b0};
    pt.green = {col, 1'b0};
    pt.last  = (int'(col) == isg_pkg::COL_COUNT - 1);
    return pt;
  endfunction

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $display("%0t: %s expected %0d got %0d", $time, name, expected, actual);
      fail_count_o++;
    end
  endtask

  initial begin
    for (int k = 0; k <= D; k++) quarter_wave[k] = taylor_quarter(k);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x    = isg_pkg::CENTER_X_RESET;
      ctr_y    = isg_pkg::CENTER_Y_RESET;
      px_scale = isg_pkg::SCALE_RESET;
      pair_x   = '0;
      pair_y   = '0;
      fail_count_o = 0;
      items_o      = 0;
      points_o     = 0;
      due_points.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (isg_pkg::cfg_reg_e'(cfg_idx_i))
          isg_pkg::REG_CENTER_X: ctr_x = cfg_data_i[isg_pkg::CTR_W-1:0];
          isg_pkg::REG_CENTER_Y: ctr_y = cfg_data_i[isg_pkg::CTR_W-1:0];
          isg_pkg::REG_SCALE:    px_scale = cfg_data_i[isg_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        due_points.push_back(trace_point(in_mon.row, in_mon.col, in_mon.time_phase));
        items_o++;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_points.size() == 0) begin
          $display("%0t: point beat expected none got x=%0d y=%0d", $time,
                   out_mon.point_x, out_mon.point_y);
          fail_count_o++;
        end else begin
          want = due_points.pop_front();
          check_field("point_x", int'(want.px), int'(out_mon.point_x));
          check_field("point_y", int'(want.py), int'(out_mon.point_y));
          check_field("red_level", int'(want.red), int'(out_mon.red_level));
          check_field("green_level", int'(want.green), int'(out_mon.green_level));
          check_field("last_in_row", int'(want.last), int'(out_mon.last_in_row));
          points_o++;
        end
      end
      pending_o <= due_points.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Top of the point generator testbench: clock, reset, stimulus, flow control and verdict.
module tb_top;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [isg_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [isg_pkg::CFG_DATA_W-1:0] cfg_data_i;
  int unsigned                    src_idle_pct;
  int unsigned                    snk_idle_pct;
  int unsigned                    fail_count, items_seen, points_seen, pending;

  isg_in_if  in_if ();
  isg_out_if out_if ();

  iterated_sincos_point_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  isg_point_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .items_o      (items_seen),
    .points_o     (points_seen),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_item(logic [isg_pkg::ROW_W-1:0] row, logic [isg_pkg::COL_W-1:0] col,
                           logic [isg_pkg::PHASE_W-1:0] tph);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.row        <= row;
    in_if.col        <= col;
    in_if.time_phase <= tph;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(isg_pkg::cfg_reg_e idx, logic [isg_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_regs(int cx, int cy, int sc);
    write_reg(isg_pkg::REG_CENTER_X, isg_pkg::CFG_DATA_W'(cx));
    write_reg(isg_pkg::REG_CENTER_Y, isg_pkg::CFG_DATA_W'(cy));
    write_reg(isg_pkg::REG_SCALE, isg_pkg::CFG_DATA_W'(sc));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int count);
    int n;
    int c;
    int first;
    int len;
    logic [isg_pkg::ROW_W-1:0]   row;
    logic [isg_pkg::PHASE_W-1:0] tph;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) < 8) begin
        row   = isg_pkg::ROW_W'($urandom_range(127));
        tph   = isg_pkg::PHASE_W'($urandom);
        first = ($urandom_range(3) == 0) ? $urandom_range(127) : 0;
        len   = ($urandom_range(7) == 0) ? 128 : $urandom_range(1, 48);
        for (c = first; c <= 127 && c < first + len && n < count; c++) begin
          send_item(row, isg_pkg::COL_W'(c), tph);
          n++;
        end
      end else begin
        send_item(isg_pkg::ROW_W'($urandom), isg_pkg::COL_W'($urandom),
                  isg_pkg::PHASE_W'($urandom));
        n++;
      end
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.row        <= '0;
    in_if.col        <= '0;
    in_if.time_phase <= '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= isg_pkg::REG_CENTER_X;
    cfg_data_i       <= '0;
    src_idle_pct = 6;
    snk_idle_pct = 87;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(7'd0, 7'd0, 16'h0000);
    send_item(7'd0, 7'd1, 16'h0000);
    send_item(7'd127, 7'd0, 16'hFFFF);
    send_item(7'd127, 7'd127, 16'hFFFF);
    send_item(7'd64, 7'd0, 16'h4000);
    send_item(7'd64, 7'd1, 16'h8000);
    send_item(7'd65, 7'd2, 16'hC000);
    send_item(7'd66, 7'd3, 16'h3FFF);
    send_item(7'd1, 7'd126, 16'h0001);
    send_item(7'd1, 7'd127, 16'h7FFF);
    send_item(7'd0, 7'd0, 16'h8000);
    send_item(7'd85, 7'd42, 16'hAAAA);
    send_item(7'd42, 7'd85, 16'h5555);
    send_item(7'd3, 7'd0, 16'h2000);
    send_item(7'd3, 7'd127, 16'h2000);
    send_item(7'd100, 7'd0, 16'hFFFF);
    send_item(7'd101, 7'd1, 16'h0000);
    send_item(7'd127, 7'd64, 16'h8001);
    in_if.valid <= 1'b0;

    for (int half = 0; half < 6; half++) begin
      drain();
      src_idle_pct = (half < 2) ? 6 : (half < 4) ? 87 : 0;
      snk_idle_pct = (half < 2) ? 87 : (half < 4) ? 6 : 0;
      case (half)
        0: set_regs(0, 0, 1023);
        1: set_regs(4095, 4095, 0);
        2: set_regs(4095, 0, 1);
        3: set_regs(0, 4095, 512);
        default: set_regs($urandom_range(4095), $urandom_range(4095), $urandom_range(1023));
      endcase
      run_random(230);
    end

    drain();
    repeat (30) @(posedge clk_i);
    $display("checked %0d points from %0d items over seven register settings,",
             points_seen, items_seen);
    $display("with sender-side idling, receiver-side idling and none");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
